FILE: design/sqvg_pkg.sv
// shared types, constants and trig helpers for the sprite quad vertex generator
package sqvg_pkg;

    localparam int MAX_SPRITES_DEF   = 1024;
    localparam int TEXTURE_SLOTS_DEF = 16;

    // angle constants in Q9.6 degrees
    localparam logic [14:0] ANGLE_FULL    = 15'd23040;
    localparam logic [14:0] ANGLE_QUARTER = 15'd5760;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEX_FULL = 2'd1;
    localparam logic [1:0] STATUS_REJECT   = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // product selectors for the shared multiplier
    localparam logic [1:0] PROD_SCX_COS = 2'd0;
    localparam logic [1:0] PROD_SCY_SIN = 2'd1;
    localparam logic [1:0] PROD_SCX_SIN = 2'd2;
    localparam logic [1:0] PROD_SCY_COS = 2'd3;

    localparam logic [15:0] SIN_TAB [0:90] = '{
        16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
        16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
        16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
        16'd12803, 16'd13328, 16'd13848, 16'd14364, 16'd14876, 16'd15383, 16'd15886,
        16'd16384, 16'd16876, 16'd17364, 16'd17846, 16'd18323, 16'd18794, 16'd19260,
        16'd19720, 16'd20173, 16'd20621, 16'd21062, 16'd21497, 16'd21925, 16'd22347,
        16'd22762, 16'd23170, 16'd23571, 16'd23964, 16'd24351, 16'd24730, 16'd25101,
        16'd25465, 16'd25821, 16'd26169, 16'd26509, 16'd26841, 16'd27165, 16'd27481,
        16'd27788, 16'd28087, 16'd28377, 16'd28659, 16'd28932, 16'd29196, 16'd29451,
        16'd29697, 16'd29934, 16'd30162, 16'd30381, 16'd30591, 16'd30791, 16'd30982,
        16'd31163, 16'd31335, 16'd31498, 16'd31650, 16'd31794, 16'd31927, 16'd32051,
        16'd32165, 16'd32269, 16'd32364, 16'd32448, 16'd32523, 16'd32588, 16'd32642,
        16'd32687, 16'd32722, 16'd32747, 16'd32762, 16'd32767
    };

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       tex;
        logic       trig;
        logic       trig_cos;
        logic       mul;
        logic [1:0] mul_sel;
        logic       out_load;
        logic       reject;
        logic [1:0] corner;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic batch_full;
    } dp_status_t;

    // sine of a whole degree 0..359, Q1.15
    function automatic logic signed [16:0] sin_whole(input logic [8:0] d);
        logic [8:0] idx;
        logic       neg;
        logic [15:0] mag;
        if (d <= 9'd90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            idx = 9'd180 - d;
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            idx = d - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - d;
            neg = 1'b1;
        end
        mag = SIN_TAB[idx[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // interpolated sine of an angle already in [0, ANGLE_FULL)
    function automatic logic signed [16:0] sin_fixed(input logic [14:0] r);
        logic [8:0]         d;
        logic [8:0]         d1;
        logic signed [16:0] s0;
        logic signed [16:0] s1;
        logic signed [17:0] diff;
        logic signed [25:0] t;
        d    = r[14:6];
        d1   = (d == 9'd359) ? 9'd0 : d + 9'd1;
        s0   = sin_whole(d);
        s1   = sin_whole(d1);
        diff = 18'(s1) - 18'(s0);
        t    = 26'(diff * $signed({1'b0, r[5:0]})) + 26'sd32;
        return 17'(26'(s0) + (t >>> 6));
    endfunction

endpackage

FILE: design/sqvg_chan_if.sv
// valid/ready channel interfaces for sprites in and vertices out
interface sqvg_sprite_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [15:0] angle_deg;
    logic [31:0] color_rgba;
    logic        has_texture;
    logic [31:0] texture_handle;
    logic [63:0] uv_first_pair;
    logic [63:0] uv_second_pair;
    modport source (output valid, cmd, pos_x, pos_y, pos_z, scale_x, scale_y, angle_deg,
                    color_rgba, has_texture, texture_handle, uv_first_pair,
                    uv_second_pair, input ready);
    modport sink (input valid, cmd, pos_x, pos_y, pos_z, scale_x, scale_y, angle_deg,
                  color_rgba, has_texture, texture_handle, uv_first_pair,
                  uv_second_pair, output ready);
endinterface

interface sqvg_vertex_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0] vert_color;
    logic [15:0] vert_u;
    logic [15:0] vert_v;
    logic [4:0]  tex_slot;
    logic [11:0] vertex_index;
    logic [1:0]  corner;
    logic        last;
    logic [1:0]  status;
    modport source (output valid, vert_x, vert_y, vert_z, vert_color, vert_u, vert_v,
                    tex_slot, vertex_index, corner, last, status, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, vert_color, vert_u, vert_v,
                  tex_slot, vertex_index, corner, last, status, output ready);
endinterface

FILE: design/sprite_quad_vertex_generator.sv
// top level of the sprite quad vertex generator
// usage:
//   sprite_ch takes one item per transfer: cmd add places a sprite in the batch,
//   cmd clear empties the batch count and the texture slot table
//   vertex_ch gives four vertex transfers per added sprite, corners in the order
//   (1,0),(1,1),(0,1),(0,0), last set on the fourth
//   a sprite arriving with the batch full gives one transfer with status 2 and
//   last set, other fields zero; a clear gives no transfer at all
// timing:
//   an added sprite goes through slot lookup and sine, cosine, four passes through
//   the one shared 32x17 multiplier, then one vertex per cycle while vertex_ch does
//   not stall, before the block is ready again
//   first vertex is registered once all four products are done
//   a rejected sprite goes through the reject state alone, a clear stays in idle
//   sprite_ch is ready only between items
// stall and reset:
//   the vertex output register holds its transfer while vertex_ch.ready is low,
//   and vertex assembly waits behind it
//   rst_n low clears the batch count, slot count, sequencer and output valid;
//   the texture table needs no reset since only live slots are compared
module sprite_quad_vertex_generator #(
    parameter int MAX_SPRITES   = sqvg_pkg::MAX_SPRITES_DEF,
    parameter int TEXTURE_SLOTS = sqvg_pkg::TEXTURE_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sqvg_sprite_if.sink   sprite_ch,
    sqvg_vertex_if.source vertex_ch
);
    import sqvg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer owns the handshakes
    sqvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sprite_ch.valid),
        .in_ready  (sprite_ch.ready),
        .out_valid (vertex_ch.valid),
        .out_ready (vertex_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath owns payload, slot table and arithmetic
    sqvg_datapath #(
        .MAX_SPRITES   (MAX_SPRITES),
        .TEXTURE_SLOTS (TEXTURE_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sprite_ch (sprite_ch),
        .vertex_ch (vertex_ch)
    );

endmodule

FILE: design/sqvg_ctrl.sv
// sequencing state machine for the sprite quad vertex generator
module sqvg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sqvg_pkg::dp_status_t status,
    output sqvg_pkg::ctrl_cmd_t  cmd
);
    import sqvg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_COS  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_REJ  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_clear)
                        cmd.clear = 1'b1;
                    else if (status.batch_full)
                        state_next = S_REJ;
                    else
                        state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.tex    = 1'b1;
                cmd.trig   = 1'b1;
                state_next = S_COS;
            end
            S_COS:
            begin
                cmd.trig     = 1'b1;
                cmd.trig_cos = 1'b1;
                cnt_next     = 2'd0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = cnt_reg;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.corner   = cnt_reg;
                    cnt_next     = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            S_REJ:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.reject   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten while stalled");
    a_mul_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && cnt_reg == 2'd3) |=> (state_reg == S_EMIT && cnt_reg == 2'd0))
        else $error("products not finished before emission");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded vertex not presented");
`endif
endmodule

FILE: design/sqvg_datapath.sv
// texture slot table, trig unit, shared multiplier and vertex output register
module sqvg_datapath #(
    parameter int MAX_SPRITES   = sqvg_pkg::MAX_SPRITES_DEF,
    parameter int TEXTURE_SLOTS = sqvg_pkg::TEXTURE_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sqvg_pkg::ctrl_cmd_t  cmd,
    output sqvg_pkg::dp_status_t status,
    sqvg_sprite_if.sink         sprite_ch,
    sqvg_vertex_if.source       vertex_ch
);
    import sqvg_pkg::*;

    localparam int CW = $clog2(MAX_SPRITES + 1);
    localparam int UW = $clog2(TEXTURE_SLOTS + 1);
    localparam int IW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

    logic [CW-1:0] count_reg;
    logic [UW-1:0] used_reg;
    logic [31:0]   tex_tab [TEXTURE_SLOTS];

    logic signed [31:0] px_reg, py_reg, pz_reg, scx_reg, scy_reg;
    logic [14:0]        ang_reg;
    logic               rot_reg;
    logic [31:0]        color_reg, handle_reg;
    logic               has_tex_reg;
    logic [63:0]        uv1_reg, uv2_reg;
    logic [4:0]         slot_reg;
    logic [1:0]         stat_reg;
    logic [CW-1:0]      base_reg;
    logic signed [16:0] sin_reg, cos_reg;
    logic signed [48:0] prod_reg [4];

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [31:0]        vcolor_reg;
    logic [15:0]        vu_reg, vv_reg;
    logic [4:0]         vslot_reg;
    logic [11:0]        vidx_reg;
    logic [1:0]         vcorner_reg;
    logic               vlast_reg;
    logic [1:0]         vstat_reg;

    // angle reduction into [0, full turn)
    logic signed [16:0] a_ext, ang_red;
    always_comb
    begin
        a_ext = 17'(sprite_ch.angle_deg);
        if (a_ext < 0)
        begin
            if (a_ext + 17'sd23040 >= 0)
                ang_red = a_ext + 17'sd23040;
            else
                ang_red = a_ext + 17'sd46080;
        end
        else if (a_ext >= 17'sd23040)
            ang_red = a_ext - 17'sd23040;
        else
            ang_red = a_ext;
    end

    // trig argument: sine angle, or sine angle plus a quarter turn
    logic [15:0]        cos_sum;
    logic [14:0]        trig_arg;
    logic signed [16:0] trig_val;
    assign cos_sum  = {1'b0, ang_reg} + {1'b0, ANGLE_QUARTER};
    assign trig_arg = !cmd.trig_cos ? ang_reg :
                      (cos_sum >= {1'b0, ANGLE_FULL}) ? 15'(cos_sum - {1'b0, ANGLE_FULL})
                                                      : cos_sum[14:0];
    assign trig_val = sin_fixed(trig_arg);

    // texture lookup over live slots, first hit wins
    logic       hit;
    logic [4:0] hit_slot;
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = 5'd0;
        for (int i = 0; i < TEXTURE_SLOTS; i++)
        begin
            if (!hit && (i < int'(used_reg)) && (tex_tab[i] == handle_reg))
            begin
                hit      = 1'b1;
                hit_slot = 5'(i + 1);
            end
        end
    end

    // shared multiplier
    logic signed [31:0] mop_a;
    logic signed [16:0] mop_b;
    assign mop_a = (cmd.mul_sel == PROD_SCX_COS || cmd.mul_sel == PROD_SCX_SIN) ? scx_reg
                                                                                : scy_reg;
    assign mop_b = (cmd.mul_sel == PROD_SCX_COS || cmd.mul_sel == PROD_SCY_COS) ? cos_reg
                                                                                : sin_reg;

    // corner vertex assembly
    logic               cx, cy;
    logic signed [49:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [31:0] vert_x_c, vert_y_c, vert_z_c;
    logic [31:0]        uv_c, idx_w;
    always_comb
    begin
        cx    = (cmd.corner == 2'd0) || (cmd.corner == 2'd1);
        cy    = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
        sum_x = (cx ? 50'(prod_reg[PROD_SCX_COS]) : 50'sd0)
              - (cy ? 50'(prod_reg[PROD_SCY_SIN]) : 50'sd0);
        sum_y = (cx ? 50'(prod_reg[PROD_SCX_SIN]) : 50'sd0)
              + (cy ? 50'(prod_reg[PROD_SCY_COS]) : 50'sd0);
        rnd_x = (sum_x + 50'sd16384) >>> 15;
        rnd_y = (sum_y + 50'sd16384) >>> 15;
        if (rot_reg)
        begin
            vert_x_c = px_reg + rnd_x[31:0];
            vert_y_c = py_reg + rnd_y[31:0];
            vert_z_c = pz_reg;
        end
        else
        begin
            vert_x_c = px_reg + (cx ? scx_reg : 32'sd0);
            vert_y_c = py_reg + (cy ? scy_reg : 32'sd0);
            vert_z_c = 32'sd0;
        end
        unique case (cmd.corner)
            2'd0:    uv_c = uv1_reg[31:0];
            2'd1:    uv_c = uv1_reg[63:32];
            2'd2:    uv_c = uv2_reg[31:0];
            default: uv_c = uv2_reg[63:32];
        endcase
        idx_w = (32'(base_reg) << 2) | 32'(cmd.corner);
    end

    assign status.is_clear   = (sprite_ch.cmd == CMD_CLEAR);
    assign status.batch_full = (32'(count_reg) >= 32'(MAX_SPRITES));

    // batch and slot counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            used_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            used_reg  <= '0;
        end
        else if (cmd.tex)
        begin
            count_reg <= count_reg + CW'(1);
            if (has_tex_reg && !hit && (32'(used_reg) < 32'(TEXTURE_SLOTS)))
                used_reg <= used_reg + UW'(1);
        end
    end

    // payload, slot table, trig, product and vertex output registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg      <= sprite_ch.pos_x;
            py_reg      <= sprite_ch.pos_y;
            pz_reg      <= sprite_ch.pos_z;
            scx_reg     <= sprite_ch.scale_x;
            scy_reg     <= sprite_ch.scale_y;
            ang_reg     <= ang_red[14:0];
            rot_reg     <= (sprite_ch.angle_deg != 16'sd0);
            color_reg   <= sprite_ch.color_rgba;
            has_tex_reg <= sprite_ch.has_texture;
            handle_reg  <= sprite_ch.texture_handle;
            uv1_reg     <= sprite_ch.uv_first_pair;
            uv2_reg     <= sprite_ch.uv_second_pair;
        end
        if (cmd.tex)
        begin
            base_reg <= count_reg;
            if (!has_tex_reg)
            begin
                slot_reg <= 5'd0;
                stat_reg <= STATUS_OK;
            end
            else if (hit)
            begin
                slot_reg <= hit_slot;
                stat_reg <= STATUS_OK;
            end
            else if (32'(used_reg) < 32'(TEXTURE_SLOTS))
            begin
                tex_tab[used_reg[IW-1:0]] <= handle_reg;
                slot_reg <= 5'(32'(used_reg) + 1);
                stat_reg <= STATUS_OK;
            end
            else
            begin
                slot_reg <= 5'd0;
                stat_reg <= STATUS_TEX_FULL;
            end
        end
        if (cmd.trig && !cmd.trig_cos)
            sin_reg <= trig_val;
        if (cmd.trig && cmd.trig_cos)
            cos_reg <= trig_val;
        if (cmd.mul)
            prod_reg[cmd.mul_sel] <= 49'(mop_a) * 49'(mop_b);
        if (cmd.out_load)
        begin
            if (cmd.reject)
            begin
                vx_reg      <= '0;
                vy_reg      <= '0;
                vz_reg      <= '0;
                vcolor_reg  <= '0;
                vu_reg      <= '0;
                vv_reg      <= '0;
                vslot_reg   <= '0;
                vidx_reg    <= '0;
                vcorner_reg <= '0;
                vlast_reg   <= 1'b1;
                vstat_reg   <= STATUS_REJECT;
            end
            else
            begin
                vx_reg      <= vert_x_c;
                vy_reg      <= vert_y_c;
                vz_reg      <= vert_z_c;
                vcolor_reg  <= color_reg;
                vu_reg      <= uv_c[15:0];
                vv_reg      <= uv_c[31:16];
                vslot_reg   <= slot_reg;
                vidx_reg    <= idx_w[11:0];
                vcorner_reg <= cmd.corner;
                vlast_reg   <= (cmd.corner == 2'd3);
                vstat_reg   <= stat_reg;
            end
        end
    end

    assign vertex_ch.vert_x       = vx_reg;
    assign vertex_ch.vert_y       = vy_reg;
    assign vertex_ch.vert_z       = vz_reg;
    assign vertex_ch.vert_color   = vcolor_reg;
    assign vertex_ch.vert_u       = vu_reg;
    assign vertex_ch.vert_v       = vv_reg;
    assign vertex_ch.tex_slot     = vslot_reg;
    assign vertex_ch.vertex_index = vidx_reg;
    assign vertex_ch.corner       = vcorner_reg;
    assign vertex_ch.last         = vlast_reg;
    assign vertex_ch.status       = vstat_reg;

`ifndef SYNTHESIS
    a_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(TEXTURE_SLOTS))
        else $error("texture slot count overran table");
    a_batch_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_SPRITES))
        else $error("sprite count overran batch");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0 && used_reg == '0))
        else $error("clear left batch state behind");
`endif
endmodule
